// ===== hdl/rsse_pkg.sv =====
// rsse_pkg: sizes, codes and word types for the random sample statistics engine
// no dependencies; used by the channel interfaces and the engine top level
package rsse_pkg;

	// sample and store sizes
	localparam int SAMPLE_BITS = 6;
	localparam int NVALS       = 1 << SAMPLE_BITS;
	localparam int GAP_BINS    = 32;
	localparam int GAP_AW      = $clog2(GAP_BINS);
	localparam int COUNT_BITS  = 32;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;

	// channel field widths
	localparam int MODE_BITS   = 3;
	localparam int FIELD_BITS  = 6;
	localparam int VALUE_BITS  = 48;
	localparam int STATUS_BITS = 2;
	localparam int CFG_BITS    = 6;

	localparam logic [CFG_BITS-1:0] GAP_LIMIT_RESET = CFG_BITS'(20);

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int OCC_BITS   = $clog2(FIFO_DEPTH + 1) + 1;

	// modes
	localparam logic [MODE_BITS-1:0] MODE_PUSH   = MODE_BITS'(0);
	localparam logic [MODE_BITS-1:0] MODE_FREQ   = MODE_BITS'(1);
	localparam logic [MODE_BITS-1:0] MODE_GAP    = MODE_BITS'(2);
	localparam logic [MODE_BITS-1:0] MODE_SCALAR = MODE_BITS'(3);
	localparam logic [MODE_BITS-1:0] MODE_CLEAR  = MODE_BITS'(4);

	// scalar selectors
	localparam logic [FIELD_BITS-1:0] SCALAR_COUNT = FIELD_BITS'(0);
	localparam logic [FIELD_BITS-1:0] SCALAR_RUNS  = FIELD_BITS'(1);
	localparam logic [FIELD_BITS-1:0] SCALAR_SUM   = FIELD_BITS'(2);
	localparam logic [FIELD_BITS-1:0] SCALAR_SQ    = FIELD_BITS'(3);
	localparam logic [FIELD_BITS-1:0] SCALAR_LAG   = FIELD_BITS'(4);

	// status codes
	localparam logic [STATUS_BITS-1:0] STATUS_OK  = STATUS_BITS'(0);
	localparam logic [STATUS_BITS-1:0] STATUS_ERR = STATUS_BITS'(1);
	localparam logic [STATUS_BITS-1:0] STATUS_SAT = STATUS_BITS'(2);

	// where a result word takes its value from
	localparam logic [1:0] SRC_DIRECT = 2'd0;
	localparam logic [1:0] SRC_FREQ   = 2'd1;
	localparam logic [1:0] SRC_GAP    = 2'd2;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// one entry of the per-value table: last position plus one, then frequency
	typedef struct packed {
		count_t last_seen;
		count_t freq;
	} value_entry_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]  value;
		logic [STATUS_BITS-1:0] status;
	} result_t;

endpackage

// ===== hdl/rsse_if.sv =====
// rsse_in_if / rsse_out_if: valid-ready channels for command and result words
// depends on rsse_pkg for field widths
interface rsse_in_if;
	logic                                valid;
	logic                                ready;
	logic [rsse_pkg::MODE_BITS-1:0]      mode;
	logic [rsse_pkg::FIELD_BITS-1:0]     sample;
	logic [rsse_pkg::FIELD_BITS-1:0]     index;

	modport source (output valid, mode, sample, index, input ready);
	modport sink   (input valid, mode, sample, index, output ready);
endinterface

interface rsse_out_if;
	logic                                valid;
	logic                                ready;
	logic [rsse_pkg::VALUE_BITS-1:0]     value;
	logic [rsse_pkg::STATUS_BITS-1:0]    status;

	modport source (output valid, value, status, input ready);
	modport sink   (input valid, value, status, output ready);
endinterface

// ===== hdl/rsse_ram.sv =====
// rsse_ram: generic single-write, single-read ram with registered read data
// read-first on a same-address collision; no dependencies
module rsse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/random_sample_statistics_engine_top.sv =====
// random_sample_statistics_engine_top: histogram, gap and moment statistics engine
// depends on rsse_pkg, rsse_in_if / rsse_out_if and rsse_ram
//
// usage
//   samples: command words (mode, sample, index); push a sample, read a frequency
//     bin, read a gap bin, read a scalar, or clear every store
//   results: one word (value, status) per command, in command order
//   cfg_we / cfg_wdata: writes gap_limit; only while no command is in flight
// path: a command taken at a clock edge is registered into stage 1, then stage 2,
//   and its result word is then written into the result queue and offered from there
// throughput: one command per cycle while samples.ready is high, back to back, pushes to the same value
//   included; the rate is set by the single read-modify-write pass over the
//   per-value ram and then the gap ram, each with a one-entry forwarding path
// reset: all statistics read as zero, gap_limit is 20; per-entry valid bits
//   make both rams read as zero at once, so no clearing pass is needed, and the
//   clear command works the same way
// stalls: results go into a four-word queue; samples.ready drops when the
//   queue plus the words still in the pipeline fill it, so nothing is lost
//   and commands resume as soon as the receiver takes words again
module random_sample_statistics_engine_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rsse_pkg::CFG_BITS-1:0]    cfg_wdata,
	rsse_in_if.sink                          samples,
	rsse_out_if.source                       results
);

	localparam int VE_BITS = $bits(rsse_pkg::value_entry_t);

	// ------------------------------------------------------------------
	// configuration and scalar state
	// ------------------------------------------------------------------
	logic [rsse_pkg::CFG_BITS-1:0]   gap_limit_q;
	rsse_pkg::count_t                sample_count_q;
	rsse_pkg::count_t                run_count_q;
	rsse_pkg::sample_t               prev_sample_q;
	logic [rsse_pkg::SUM_BITS-1:0]   value_sum_q;
	logic [rsse_pkg::SQ_BITS-1:0]    square_sum_q;
	logic [rsse_pkg::SQ_BITS-1:0]    lag_sum_q;
	logic                            saturated_q;

	// valid bits of both rams
	logic [rsse_pkg::NVALS-1:0]      a_valid_q;
	logic [rsse_pkg::GAP_BINS-1:0]   g_valid_q;

	// ------------------------------------------------------------------
	// stage 0: command accept, scalar update, per-value ram read
	// ------------------------------------------------------------------
	logic                            acc;
	logic [rsse_pkg::MODE_BITS-1:0]  mode;
	rsse_pkg::sample_t               x;
	logic [rsse_pkg::FIELD_BITS-1:0] idx;
	logic                            is_push;
	logic                            is_clear;
	logic                            count_full;
	logic                            push_ok;
	logic [rsse_pkg::PROD_BITS-1:0]  sq_prod;
	logic [rsse_pkg::PROD_BITS-1:0]  lag_prod;
	logic                            crossing;
	logic [rsse_pkg::VALUE_BITS-1:0] val0;
	logic                            bad0;
	logic                            sat_after;
	logic [rsse_pkg::STATUS_BITS-1:0] status0;
	logic [1:0]                      src0;
	rsse_pkg::sample_t               a_raddr;
	logic                            freq_ok;
	logic                            gap_ok;

	assign acc      = samples.valid & samples.ready;
	assign mode     = samples.mode;
	assign x        = samples.sample[rsse_pkg::SAMPLE_BITS-1:0];
	assign idx      = samples.index;
	assign is_push  = acc && (mode == rsse_pkg::MODE_PUSH);
	assign is_clear = acc && (mode == rsse_pkg::MODE_CLEAR);
	assign count_full = &sample_count_q;
	assign push_ok  = is_push && !count_full;

	assign sq_prod  = x * x;
	assign lag_prod = prev_sample_q * x;
	// midpoint (N-1)/2 is a half-integer, so above/below is just the top bit
	assign crossing = x[rsse_pkg::SAMPLE_BITS-1] != prev_sample_q[rsse_pkg::SAMPLE_BITS-1];

	assign freq_ok = 32'(idx) < 32'(rsse_pkg::NVALS);
	assign gap_ok  = 32'(idx) < 32'(rsse_pkg::GAP_BINS);

	// per-value ram address: the sample for a push, the bin for a read
	assign a_raddr = (mode == rsse_pkg::MODE_PUSH) ? x : idx[rsse_pkg::SAMPLE_BITS-1:0];

	// result value known at accept time, or the ram it comes from
	always_comb begin
		val0 = '0;
		bad0 = 1'b0;
		src0 = rsse_pkg::SRC_DIRECT;
		sat_after = saturated_q;
		case (mode)
			rsse_pkg::MODE_PUSH: begin
				if (count_full) begin
					val0 = rsse_pkg::VALUE_BITS'(sample_count_q);
					sat_after = 1'b1;
				end else begin
					val0 = rsse_pkg::VALUE_BITS'(sample_count_q) + 1'b1;
				end
			end
			rsse_pkg::MODE_FREQ: begin
				if (freq_ok) src0 = rsse_pkg::SRC_FREQ;
				else bad0 = 1'b1;
			end
			rsse_pkg::MODE_GAP: begin
				if (gap_ok) src0 = rsse_pkg::SRC_GAP;
				else bad0 = 1'b1;
			end
			rsse_pkg::MODE_SCALAR: begin
				case (idx)
					rsse_pkg::SCALAR_COUNT: val0 = rsse_pkg::VALUE_BITS'(sample_count_q);
					rsse_pkg::SCALAR_RUNS:  val0 = rsse_pkg::VALUE_BITS'(run_count_q);
					rsse_pkg::SCALAR_SUM:   val0 = rsse_pkg::VALUE_BITS'(value_sum_q);
					rsse_pkg::SCALAR_SQ:    val0 = rsse_pkg::VALUE_BITS'(square_sum_q);
					rsse_pkg::SCALAR_LAG:   val0 = rsse_pkg::VALUE_BITS'(lag_sum_q);
					default:                bad0 = 1'b1;
				endcase
			end
			rsse_pkg::MODE_CLEAR: begin
				sat_after = 1'b0;
			end
			default: begin
				bad0 = 1'b1;
			end
		endcase
		if (bad0) begin
			val0 = '0;
			src0 = rsse_pkg::SRC_DIRECT;
		end
	end

	assign status0 = bad0 ? rsse_pkg::STATUS_ERR :
	                 sat_after ? rsse_pkg::STATUS_SAT : rsse_pkg::STATUS_OK;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= rsse_pkg::GAP_LIMIT_RESET;
		end else if (cfg_we) begin
			gap_limit_q <= cfg_wdata;
		end
	end

	// scalar statistics, updated in command order at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			run_count_q    <= '0;
			prev_sample_q  <= '0;
			value_sum_q    <= '0;
			square_sum_q   <= '0;
			lag_sum_q      <= '0;
			saturated_q    <= 1'b0;
		end else if (is_clear) begin
			sample_count_q <= '0;
			run_count_q    <= '0;
			prev_sample_q  <= '0;
			value_sum_q    <= '0;
			square_sum_q   <= '0;
			lag_sum_q      <= '0;
			saturated_q    <= 1'b0;
		end else if (is_push) begin
			if (count_full) begin
				// dropped sample, sticky flag
				saturated_q <= 1'b1;
			end else begin
				sample_count_q <= sample_count_q + 1'b1;
				if (sample_count_q == '0) begin
					// first sample opens one run, no lag product yet
					run_count_q <= rsse_pkg::COUNT_BITS'(1);
				end else begin
					if (crossing) run_count_q <= run_count_q + 1'b1;
					lag_sum_q <= lag_sum_q + rsse_pkg::SQ_BITS'(lag_prod);
				end
				value_sum_q   <= value_sum_q + rsse_pkg::SUM_BITS'(x);
				square_sum_q  <= square_sum_q + rsse_pkg::SQ_BITS'(sq_prod);
				prev_sample_q <= x;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: per-value entry read back, updated and written; gap ram read
	// ------------------------------------------------------------------
	logic                            vld_s1;
	logic                            push_s1;
	rsse_pkg::sample_t               addr_s1;
	rsse_pkg::count_t                pos_s1;
	logic [1:0]                      src_s1;
	logic [rsse_pkg::VALUE_BITS-1:0] val_s1;
	logic [rsse_pkg::STATUS_BITS-1:0] status_s1;
	logic [rsse_pkg::GAP_AW-1:0]     gidx_s1;
	logic                            a_vld_rd_s1;

	logic [VE_BITS-1:0]              a_rdata;
	logic                            afwd_vld_q;
	rsse_pkg::sample_t               afwd_addr_q;
	rsse_pkg::value_entry_t          afwd_data_q;

	rsse_pkg::value_entry_t          a_cur;
	rsse_pkg::value_entry_t          a_new;
	logic                            a_we;
	rsse_pkg::count_t                pos_p1;
	rsse_pkg::count_t                gap;
	logic                            gap_hit;
	logic [rsse_pkg::GAP_AW-1:0]     g_raddr;
	logic [rsse_pkg::VALUE_BITS-1:0] val_s1_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			push_s1 <= 1'b0;
		end else begin
			vld_s1  <= acc;
			push_s1 <= push_ok;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= a_raddr;
		pos_s1      <= sample_count_q;
		src_s1      <= src0;
		val_s1      <= val0;
		status_s1   <= status0;
		gidx_s1     <= idx[rsse_pkg::GAP_AW-1:0];
		a_vld_rd_s1 <= a_valid_q[a_raddr];
	end

	rsse_ram #(
		.WIDTH (VE_BITS),
		.DEPTH (rsse_pkg::NVALS)
	) u_value_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (addr_s1),
		.wdata (a_new),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// the write from the previous cycle is missed by the read-first ram: forward it
	always_comb begin
		if (afwd_vld_q && (afwd_addr_q == addr_s1)) begin
			a_cur = afwd_data_q;
		end else if (a_vld_rd_s1) begin
			a_cur = rsse_pkg::value_entry_t'(a_rdata);
		end else begin
			a_cur = '0;
		end
	end

	assign a_we            = vld_s1 & push_s1;
	assign pos_p1          = pos_s1 + 1'b1;
	assign a_new.freq      = a_cur.freq + 1'b1;
	assign a_new.last_seen = pos_p1;

	// repeat gap from the last position of this value
	assign gap     = pos_p1 - a_cur.last_seen;
	assign gap_hit = (a_cur.last_seen != '0) &&
	                 (gap < {{(rsse_pkg::COUNT_BITS - rsse_pkg::CFG_BITS){1'b0}}, gap_limit_q}) &&
	                 (gap < rsse_pkg::COUNT_BITS'(rsse_pkg::GAP_BINS));
	assign g_raddr = push_s1 ? gap[rsse_pkg::GAP_AW-1:0] : gidx_s1;

	assign val_s1_out = (src_s1 == rsse_pkg::SRC_FREQ) ?
	                    rsse_pkg::VALUE_BITS'(a_cur.freq) : val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			afwd_vld_q <= 1'b0;
		end else begin
			afwd_vld_q <= a_we & ~is_clear;
		end
	end

	always_ff @(posedge clk) begin
		afwd_addr_q <= addr_s1;
		afwd_data_q <= a_new;
	end

	// valid bits: clear wins over a write landing in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= '0;
		end else if (is_clear) begin
			a_valid_q <= '0;
		end else if (a_we) begin
			a_valid_q[addr_s1] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: gap bin read back, updated and written; result to the queue
	// ------------------------------------------------------------------
	logic                            vld_s2;
	logic                            gwr_s2;
	logic [rsse_pkg::GAP_AW-1:0]     gaddr_s2;
	logic [1:0]                      src_s2;
	logic [rsse_pkg::VALUE_BITS-1:0] val_s2;
	logic [rsse_pkg::STATUS_BITS-1:0] status_s2;
	logic                            g_vld_rd_s2;

	rsse_pkg::count_t                g_rdata;
	logic                            gfwd_vld_q;
	logic [rsse_pkg::GAP_AW-1:0]     gfwd_addr_q;
	rsse_pkg::count_t                gfwd_data_q;
	rsse_pkg::count_t                g_cur;
	rsse_pkg::count_t                g_new;
	logic                            g_we;
	rsse_pkg::result_t               res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			gwr_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			// a clear behind this push cancels its gap update
			gwr_s2 <= vld_s1 & push_s1 & gap_hit & ~is_clear;
		end
	end

	always_ff @(posedge clk) begin
		gaddr_s2    <= g_raddr;
		src_s2      <= src_s1;
		val_s2      <= val_s1_out;
		status_s2   <= status_s1;
		g_vld_rd_s2 <= g_valid_q[g_raddr];
	end

	rsse_ram #(
		.WIDTH (rsse_pkg::COUNT_BITS),
		.DEPTH (rsse_pkg::GAP_BINS)
	) u_gap_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (gaddr_s2),
		.wdata (g_new),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	always_comb begin
		if (gfwd_vld_q && (gfwd_addr_q == gaddr_s2)) begin
			g_cur = gfwd_data_q;
		end else if (g_vld_rd_s2) begin
			g_cur = g_rdata;
		end else begin
			g_cur = '0;
		end
	end

	assign g_we  = vld_s2 & gwr_s2;
	assign g_new = g_cur + 1'b1;

	// the word reading this forward was accepted ahead of any clear taken now
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gfwd_vld_q <= 1'b0;
		end else begin
			gfwd_vld_q <= g_we;
		end
	end

	always_ff @(posedge clk) begin
		gfwd_addr_q <= gaddr_s2;
		gfwd_data_q <= g_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_valid_q <= '0;
		end else if (is_clear) begin
			g_valid_q <= '0;
		end else if (g_we) begin
			g_valid_q[gaddr_s2] <= 1'b1;
		end
	end

	assign res_s2.value  = (src_s2 == rsse_pkg::SRC_GAP) ?
	                       rsse_pkg::VALUE_BITS'(g_cur) : val_s2;
	assign res_s2.status = status_s2;

	// ------------------------------------------------------------------
	// result queue; admission counts words still in the pipeline
	// ------------------------------------------------------------------
	rsse_pkg::result_t               fifo_q [rsse_pkg::FIFO_DEPTH];
	logic [rsse_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [rsse_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [rsse_pkg::OCC_BITS-1:0]   occ_q;
	logic [rsse_pkg::OCC_BITS-1:0]   pending;
	logic                            pop;

	assign pending = occ_q + rsse_pkg::OCC_BITS'(vld_s1) + rsse_pkg::OCC_BITS'(vld_s2);
	assign samples.ready = pending < rsse_pkg::OCC_BITS'(rsse_pkg::FIFO_DEPTH);

	assign results.valid  = occ_q != '0;
	assign results.value  = fifo_q[rd_ptr_q].value;
	assign results.status = fifo_q[rd_ptr_q].status;
	assign pop = results.valid & results.ready;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			fifo_q[wr_ptr_q] <= res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (vld_s2) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({vld_s2, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

endmodule
